FILE: rtl/core/plks_pkg.sv
// plks_pkg: shared types, constants and helpers for the pooled linked-list key store
// used by the controller, datapath and top level; no dependencies
`default_nettype none
package plks_pkg;
  localparam int POOL_BLOCKS = 64;
  localparam int VALUE_BYTES = 8;
  localparam int BW = $clog2(POOL_BLOCKS);
  localparam int FW = $clog2(POOL_BLOCKS + 1);
  localparam int VW = 8 * VALUE_BYTES;

  typedef logic [BW-1:0] blk_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOT_FND  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic latch;    // capture request, start read of head
    logic ins;      // write new record at lowest free
    logic step;     // advance walk to next record
    logic unlink;   // remove current record
    logic scan;     // advance free scan by one block
    logic res_ok;   // load result from current record
    logic res_err;  // load error result
    logic res_ins;  // load result from inserted record
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic   too_long;
    logic   full;
    logic   empty;
    logic   hit;
    logic   last;
    logic   scan_done;
  } sts_t;

  function automatic logic [VW-1:0] byte_mask(input logic [3:0] len);
    logic [VW-1:0] m;
    m = '0;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      if (32'(i) < 32'(len)) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/plks_ctrl.sv
// plks_ctrl: request sequencer for the key store
// depends on plks_pkg
`default_nettype none
module plks_ctrl import plks_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire mode_t in_mode,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_WALK  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DONE  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  mode_t  mode_r;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    if (in_valid && in_ready) mode_r <= in_mode;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (mode_r == MODE_INSERT) begin
          if (sts.too_long || sts.full) begin
            cmd.res_err = 1'b1;
            state_nxt   = S_WAIT;
          end else begin
            cmd.ins     = 1'b1;
            cmd.res_ins = 1'b1;
            state_nxt   = S_SCAN;
          end
        end else if (sts.empty) begin
          cmd.res_err = 1'b1;
          state_nxt   = S_WAIT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.hit) begin
          cmd.res_ok = 1'b1;
          if (mode_r != MODE_LOOKUP) begin
            cmd.unlink = 1'b1;
          end
          state_nxt = S_WAIT;
        end else if (sts.last) begin
          cmd.res_err = 1'b1;
          state_nxt   = S_WAIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_WAIT;
        else cmd.scan = 1'b1;
      end
      S_WAIT: begin
        ov_nxt    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ov_r && out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/plks_dpath.sv
// plks_dpath: record memories, list pointers, free scan and result registers
// depends on plks_pkg
`default_nettype none
module plks_dpath import plks_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_wdata,
  input  wire mode_t         in_mode,
  input  wire logic [31:0]   in_key,
  input  wire logic [VW-1:0] in_value_in,
  input  wire logic [3:0]    in_value_len_in,
  input  wire cmd_t          cmd,
  output sts_t              sts,
  output status_t           out_status,
  output logic [31:0]       out_key_out,
  output logic [VW-1:0]     out_value_out,
  output logic [3:0]        out_value_len_out,
  output logic [5:0]        out_block_index
);
  logic [31:0]   mem_key [POOL_BLOCKS];
  logic [VW-1:0] mem_val [POOL_BLOCKS];
  logic [3:0]    mem_len [POOL_BLOCKS];
  logic [BW-1:0] mem_lnk [POOL_BLOCKS];
  logic          mem_hl  [POOL_BLOCKS];
  logic [POOL_BLOCKS-1:0] occ_r;

  blk_t    head_r, tail_r, cur_r, prev_r;
  logic    nonempty_r, has_prev_r;
  logic [FW-1:0] free_r, scan_r;
  logic [3:0]    max_r;
  mode_t   mode_r;
  logic [31:0]   key_r;
  logic [VW-1:0] val_r;
  logic [3:0]    len_r;

  // registered read of the current record
  logic [31:0]   c_key_r;
  logic [VW-1:0] c_val_r;
  logic [3:0]    c_len_r;
  blk_t          c_lnk_r;
  logic          c_hl_r;
  blk_t          rd_addr;
  assign rd_addr = cmd.latch ? head_r : (cmd.step ? c_lnk_r : cur_r);

  logic [3:0] limit;
  assign limit = (max_r < 4'(VALUE_BYTES)) ? max_r : 4'(VALUE_BYTES);

  blk_t free_b;
  assign free_b = free_r[BW-1:0];

  assign sts.too_long  = len_r > limit;
  assign sts.full      = free_r == FW'(POOL_BLOCKS);
  assign sts.empty     = !nonempty_r;
  assign sts.hit       = (mode_r == MODE_REMOVE) ? (cur_r == tail_r) : (c_key_r == key_r);
  assign sts.last      = !c_hl_r;
  assign sts.scan_done = (scan_r == FW'(POOL_BLOCKS)) || !occ_r[scan_r[BW-1:0]];

  always_ff @(posedge clk) begin
    c_key_r <= mem_key[rd_addr];
    c_val_r <= mem_val[rd_addr];
    c_len_r <= mem_len[rd_addr];
    c_lnk_r <= mem_lnk[rd_addr];
    c_hl_r  <= mem_hl[rd_addr];
    if (cmd.latch) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      val_r  <= in_value_in;
      len_r  <= in_value_len_in;
      cur_r  <= head_r;
    end
    if (cmd.step) begin
      prev_r <= cur_r;
      cur_r  <= c_lnk_r;
    end
    if (cmd.ins) begin
      mem_key[free_b] <= key_r;
      mem_val[free_b] <= val_r & byte_mask(len_r);
      mem_len[free_b] <= len_r;
      mem_hl[free_b]  <= 1'b0;
      mem_lnk[free_b] <= '0;
      if (nonempty_r) begin
        mem_lnk[tail_r] <= free_b;
        mem_hl[tail_r]  <= 1'b1;
      end
    end
    if (cmd.unlink) begin
      mem_hl[cur_r] <= 1'b0;
      if (has_prev_r) begin
        if (cur_r == tail_r) mem_hl[prev_r] <= 1'b0;
        else begin
          mem_lnk[prev_r] <= c_lnk_r;
          mem_hl[prev_r]  <= c_hl_r;
        end
      end
    end
    if (cmd.res_err) begin
      out_status        <= (mode_r == MODE_INSERT) ? (sts.too_long ? ST_TOO_LONG : ST_FULL)
                         : (mode_r == MODE_REMOVE) ? ST_EMPTY : ST_NOT_FND;
      out_key_out       <= '0;
      out_value_out     <= '0;
      out_value_len_out <= '0;
      out_block_index   <= '0;
    end
    if (cmd.res_ok) begin
      out_status        <= ST_OK;
      out_key_out       <= c_key_r;
      out_value_out     <= c_val_r;
      out_value_len_out <= c_len_r;
      out_block_index   <= 6'(cur_r);
    end
    if (cmd.res_ins) begin
      out_status        <= ST_OK;
      out_key_out       <= key_r;
      out_value_out     <= val_r & byte_mask(len_r);
      out_value_len_out <= len_r;
      out_block_index   <= 6'(free_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      nonempty_r <= 1'b0;
      free_r     <= '0;
      scan_r     <= '0;
      max_r      <= 4'd8;
      has_prev_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (cmd.latch) has_prev_r <= 1'b0;
      if (cmd.step) has_prev_r <= 1'b1;
      if (cmd.ins) begin
        occ_r[free_b] <= 1'b1;
        if (!nonempty_r) head_r <= free_b;
        nonempty_r <= 1'b1;
        tail_r     <= free_b;
        scan_r     <= free_r + 1'b1;
        free_r     <= free_r + 1'b1;
      end
      if (cmd.scan) begin
        scan_r <= scan_r + 1'b1;
        free_r <= scan_r + 1'b1;
      end
      if (cmd.unlink) begin
        occ_r[cur_r] <= 1'b0;
        if (FW'(cur_r) < free_r) free_r <= FW'(cur_r);
        if (!has_prev_r) begin
          if (!c_hl_r) begin
            nonempty_r <= 1'b0;
            head_r     <= '0;
            tail_r     <= '0;
          end else head_r <= c_lnk_r;
        end else if (cur_r == tail_r) tail_r <= prev_r;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/pool_linked_list_key_store.sv
// pool_linked_list_key_store: top level, joins the sequencer and the datapath
// depends on plks_pkg, plks_ctrl, plks_dpath
//
// channel | direction | handshake
// in_*    | in        | in_valid / in_ready
// out_*   | out       | out_valid / out_ready
// cfg_*   | in        | cfg_we, no wait
//
// insert: the result is loaded at decode and offered once the free-block scan has skipped
//   the occupied blocks that follow the new record
// delete, lookup, remove-last: the walk examines records in list order, up to 64;
//   errors found at decode skip the walk
// one request at a time; the next is taken in the cycle after the result is accepted
// synchronous reset clears the list and the occupied flags and sets the limit to 8
`default_nettype none
module pool_linked_list_key_store import plks_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_key,
  input  wire logic [63:0] in_value_in,
  input  wire logic [3:0]  in_value_len_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_key_out,
  output logic [63:0]      out_value_out,
  output logic [3:0]       out_value_len_out,
  output logic [5:0]       out_block_index,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);
  cmd_t    cmd;
  sts_t    sts;
  status_t st;

  plks_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode(mode_t'(in_mode)),
    .out_valid, .out_ready, .cmd, .sts
  );

  plks_dpath u_dpath (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_mode(mode_t'(in_mode)), .in_key,
    .in_value_in, .in_value_len_in, .cmd, .sts, .out_status(st), .out_key_out,
    .out_value_out, .out_value_len_out, .out_block_index
  );

  assign out_status = st;
endmodule
`default_nettype wire

FILE: rtl/core/plks_checker.sv
// plks_checker: port-level checks on the key store
// bound to pool_linked_list_key_store
`default_nettype none
module plks_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_key_out,
  input wire logic [5:0]  out_block_index
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd4) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 3'd0) |-> (out_key_out == 0 && out_block_index == 0))
    else $error("error result carries data");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_key_out)))
    else $error("result dropped");
endmodule

bind pool_linked_list_key_store plks_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_key_out, .out_block_index
);
`default_nettype wire

FILE: tb/pool_linked_list_key_store_tb.sv
// pool_linked_list_key_store_tb: self-checking bench for the pooled linked-list key store
// drives random and directed requests, predicts each result and compares field by field
// depends on plks_pkg and pool_linked_list_key_store
`timescale 1ns / 100ps
`default_nettype none
module pool_linked_list_key_store_tb;
  import plks_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] key;
    logic [63:0] value;
    logic [3:0]  len;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] key;
    logic [63:0] value;
    logic [3:0]  len;
    logic [5:0]  blk;
  } record_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [31:0] in_key = '0;
  logic [63:0] in_value_in = '0;
  logic [3:0] in_value_len_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_key_out;
  logic [63:0] out_value_out;
  logic [3:0] out_value_len_out;
  logic [5:0] out_block_index;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  pool_linked_list_key_store u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_key, .in_value_in, .in_value_len_in,
    .out_valid, .out_ready, .out_status, .out_key_out, .out_value_out, .out_value_len_out,
    .out_block_index, .cfg_we, .cfg_wdata
  );

  always #4 clk = ~clk;

  // predicted store
  logic [31:0] pool_key [POOL_BLOCKS];
  logic [63:0] pool_value [POOL_BLOCKS];
  logic [3:0] pool_len [POOL_BLOCKS];
  int pool_link [POOL_BLOCKS];
  bit pool_has_link [POOL_BLOCKS];
  bit pool_used [POOL_BLOCKS];
  int head, tail, free_blk;
  bit nonempty;
  logic [3:0] max_len;

  request_t pending_q[$];
  record_t expected_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit holding = 1'b0;
  event hold_start;
  int errors = 0;
  int cycles = 0;
  int live_keys[$];

  function automatic logic [63:0] len_mask(input logic [3:0] n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic record_t store_apply(input request_t r);
    record_t res;
    int lim, cur, prev, b;
    bit has_prev, hit;
    res = '0;
    res.status = ST_OK;
    lim = (max_len < VALUE_BYTES) ? max_len : VALUE_BYTES;
    if (r.mode == MODE_INSERT) begin
      if (r.len > lim) begin
        res.status = ST_TOO_LONG;
        return res;
      end
      if (free_blk >= POOL_BLOCKS) begin
        res.status = ST_FULL;
        return res;
      end
      b = free_blk;
      pool_key[b] = r.key;
      pool_value[b] = r.value & len_mask(r.len);
      pool_len[b] = r.len;
      pool_has_link[b] = 0;
      pool_link[b] = 0;
      pool_used[b] = 1;
      if (!nonempty) begin
        head = b;
        nonempty = 1;
      end else begin
        pool_link[tail] = b;
        pool_has_link[tail] = 1;
      end
      tail = b;
      free_blk = POOL_BLOCKS;
      for (int i = POOL_BLOCKS - 1; i > b; i--) if (!pool_used[i]) free_blk = i;
      res.key = r.key;
      res.value = pool_value[b];
      res.len = r.len;
      res.blk = 6'(b);
      return res;
    end
    res.status = (r.mode == MODE_REMOVE) ? ST_EMPTY : ST_NOT_FND;
    if (!nonempty) return res;
    cur = head;
    prev = 0;
    has_prev = 0;
    for (int s = 0; s < POOL_BLOCKS; s++) begin
      hit = (r.mode == MODE_REMOVE) ? (cur == tail) : (pool_key[cur] == r.key);
      if (hit) begin
        res.status = ST_OK;
        res.key = pool_key[cur];
        res.value = pool_value[cur];
        res.len = pool_len[cur];
        res.blk = 6'(cur);
        if (r.mode != MODE_LOOKUP) begin
          if (!has_prev) begin
            if (!pool_has_link[cur]) begin
              nonempty = 0;
              head = 0;
              tail = 0;
            end else head = pool_link[cur];
          end else if (cur == tail) begin
            pool_has_link[prev] = 0;
            tail = prev;
          end else begin
            pool_link[prev] = pool_link[cur];
            pool_has_link[prev] = pool_has_link[cur];
          end
          pool_used[cur] = 0;
          pool_has_link[cur] = 0;
          if (cur < free_blk) free_blk = cur;
        end
        return res;
      end
      if (!pool_has_link[cur]) break;
      prev = cur;
      has_prev = 1;
      cur = pool_link[cur];
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(store_apply(request_t'({in_mode, in_key, in_value_in,
                                                     in_value_len_in})));
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_mode <= pending_q[0].mode;
          in_key <= pending_q[0].key;
          in_value_in <= pending_q[0].value;
          in_value_len_in <= pending_q[0].len;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always begin
    @(hold_start);
    holding <= 1'b1;
    repeat (300) @(posedge clk);
    holding <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    record_t exp_r;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result status=%0d", out_status);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_status); errors++;
          end
          if (out_key_out !== exp_r.key) begin
            $error("key_out exp %h got %h", exp_r.key, out_key_out); errors++;
          end
          if (out_value_out !== exp_r.value) begin
            $error("value_out exp %h got %h", exp_r.value, out_value_out); errors++;
          end
          if (out_value_len_out !== exp_r.len) begin
            $error("value_len_out exp %0d got %0d", exp_r.len, out_value_len_out);
            errors++;
          end
          if (out_block_index !== exp_r.blk) begin
            $error("block_index exp %0d got %0d", exp_r.blk, out_block_index);
            errors++;
          end
        end
      end
      if (holding) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("[pool_linked_list_key_store] ERROR");
      $finish;
    end
  end

  task automatic push_req(input mode_t m, input logic [31:0] k, input logic [63:0] v,
                          input logic [3:0] n);
    request_t r;
    r.mode = m;
    r.key = k;
    r.value = v;
    r.len = n;
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len = v;
  endtask

  task automatic random_items(input int count);
    int sel;
    logic [31:0] key_v;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      key_v = (live_keys.size() > 0 && $urandom_range(3) != 0)
              ? live_keys[$urandom_range(live_keys.size() - 1)]
              : ($urandom_range(4) == 0 ? $urandom() : 32'($urandom_range(7)));
      if (sel < 45) begin
        push_req(MODE_INSERT, key_v, {$urandom(), $urandom()},
                 ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8)));
        live_keys.push_back(key_v);
        if (live_keys.size() > 32) void'(live_keys.pop_front());
      end else if (sel < 65) begin
        push_req(MODE_DELETE, key_v, {$urandom(), $urandom()}, 4'($urandom_range(15)));
      end else if (sel < 85) begin
        push_req(MODE_LOOKUP, key_v, {$urandom(), $urandom()}, 4'($urandom_range(15)));
      end else begin
        push_req(MODE_REMOVE, key_v, {$urandom(), $urandom()}, 4'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_BLOCKS; i++) begin
      pool_used[i] = 0;
      pool_has_link[i] = 0;
      pool_link[i] = 0;
    end
    head = 0;
    tail = 0;
    nonempty = 0;
    free_blk = 0;
    max_len = 4'd8;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, duplicates, errors
    push_req(MODE_DELETE, 32'h0, '0, 4'd0);
    push_req(MODE_LOOKUP, 32'h0, '0, 4'd0);
    push_req(MODE_REMOVE, 32'h0, '0, 4'd0);
    push_req(MODE_INSERT, 32'h8000_0000, '1, 4'd8);
    push_req(MODE_INSERT, 32'h7fff_ffff, 64'h0123_4567_89ab_cdef, 4'd3);
    push_req(MODE_INSERT, 32'h8000_0000, '1, 4'd0);
    push_req(MODE_INSERT, 32'hffff_ffff, '1, 4'd15);
    push_req(MODE_INSERT, 32'hffff_ffff, '1, 4'd9);
    push_req(MODE_LOOKUP, 32'h8000_0000, '0, 4'd0);
    push_req(MODE_REMOVE, 32'h0, '0, 4'd0);
    push_req(MODE_LOOKUP, 32'h8000_0000, '0, 4'd0);
    push_req(MODE_DELETE, 32'h7fff_ffff, '0, 4'd0);
    push_req(MODE_DELETE, 32'h1234_5678, '0, 4'd0);
    push_req(MODE_INSERT, 32'h5, 64'haaaa_5555_aaaa_5555, 4'd7);
    push_req(MODE_DELETE, 32'h8000_0000, '0, 4'd0);
    push_req(MODE_REMOVE, 32'h0, '0, 4'd0);
    push_req(MODE_REMOVE, 32'h0, '0, 4'd0);

    // fill the pool behind a long receiver hold-off, then hit pool full
    drain();
    -> hold_start;
    for (int i = 0; i < POOL_BLOCKS + 2; i++)
      push_req(MODE_INSERT, 32'(i), {$urandom(), $urandom()}, 4'($urandom_range(8)));
    push_req(MODE_LOOKUP, 32'(POOL_BLOCKS - 1), '0, 4'd0);
    push_req(MODE_DELETE, 32'd10, '0, 4'd0);
    push_req(MODE_DELETE, 32'd3, '0, 4'd0);
    push_req(MODE_INSERT, 32'd99, '1, 4'd2);
    for (int i = 0; i < POOL_BLOCKS + 2; i++) push_req(MODE_REMOVE, '0, '0, 4'd0);

    // random phases with several limits and idling patterns
    write_limit(4'd0);
    random_items(40);
    write_limit(4'd15);
    send_idle_pct = 83;
    random_items(60);
    write_limit(4'd4);
    send_idle_pct = 0;
    recv_idle_pct = 83;
    random_items(60);
    write_limit(4'd8);
    send_idle_pct = 31;
    recv_idle_pct = 31;
    random_items(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(30);

    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[pool_linked_list_key_store] OK");
    end else begin
      $display("[pool_linked_list_key_store] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: pool_linked_list_key_store.f
rtl/core/plks_pkg.sv
rtl/core/plks_ctrl.sv
rtl/core/plks_dpath.sv
rtl/core/pool_linked_list_key_store.sv
rtl/core/plks_checker.sv
tb/pool_linked_list_key_store_tb.sv
